### design/proximity_point_trigger_unit_assert.svh
// Assertion macros for the proximity point trigger unit checker.
// Depends on nothing; included by the checker file only.
`ifndef PROXIMITY_POINT_TRIGGER_UNIT_ASSERT_SVH
`define PROXIMITY_POINT_TRIGGER_UNIT_ASSERT_SVH

// Clocked property, switched off while reset is high
`define PPT_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that also holds across reset
`define PPT_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ppt_pkg.sv
// Shared types and constants for the proximity point trigger unit.
// No dependencies; imported by every module of the block.
package ppt_pkg;

   // Field widths
   localparam int IDX_BITS     = 6;
   localparam int POS_BITS     = 36;
   localparam int DIR_BITS     = 2;
   localparam int DIST_BITS    = 20;
   localparam int POINTS_BITS  = 7;
   localparam int CSR_IDX_BITS = 2;
   localparam int DIFF_BITS    = POS_BITS + 1;

   // Upper bound on entries walked by one check
   localparam int MAX_SCAN = 64;

   // Register reset values
   localparam logic [DIST_BITS-1:0]   WARN_RESET   = 20'd30000;
   localparam logic [DIST_BITS-1:0]   REARM_RESET  = 20'd10000;
   localparam logic [POINTS_BITS-1:0] POINTS_RESET = 7'd0;

   // Item actions
   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_CHECK = 1'b1
   } ppt_action_type;

   // Register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WARNING = 2'd0,
      CSR_REARM   = 2'd1,
      CSR_POINTS  = 2'd2
   } ppt_csr_type;

   // Sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_SCAN = 1'b1
   } ppt_state_type;

   typedef struct packed {
      logic                action;
      logic [IDX_BITS-1:0] entry_index;
      logic [POS_BITS-1:0] position_mm;
      logic [DIR_BITS-1:0] direction;
      logic                direction_any;
   } ppt_req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]  point_index;
      logic [DIST_BITS-1:0] distance_mm;
      logic                 last;
   } ppt_rsp_type;

   // One stored track point
   typedef struct packed {
      logic [POS_BITS-1:0] position;
      logic [DIR_BITS-1:0] direction;
   } ppt_entry_type;

   // Access controls from the sequencer to the point table
   typedef struct packed {
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_idx;
      ppt_entry_type       wr_entry;
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_idx;
      logic                lat_en;
      logic [IDX_BITS-1:0] lat_idx;
      logic                lat_val;
   } ppt_tbl_ctl_type;

endpackage

### design/ppt_table.sv
// Point table: position/direction memory with a registered read port,
// plus the per-entry trigger latches. Depends on ppt_pkg.
module ppt_table #(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ppt_pkg::ppt_tbl_ctl_type  ctl,
   output ppt_pkg::ppt_entry_type    rd_entry,
   output logic                      latch_q
);
   import ppt_pkg::*;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   ppt_entry_type     mem [DEPTH];
   ppt_entry_type     rd_entry_ff;
   logic [DEPTH-1:0]  latch_ff;

   // Write one entry, read one entry a cycle with registered data
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_idx[ADDR_W-1:0]] <= ctl.wr_entry;
      end
      if (ctl.rd_en) begin
         rd_entry_ff <= mem[ctl.rd_idx[ADDR_W-1:0]];
      end
   end

   // Trigger latches, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
      end else if (ctl.lat_en) begin
         latch_ff[ctl.lat_idx[ADDR_W-1:0]] <= ctl.lat_val;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign latch_q  = latch_ff[ctl.lat_idx[ADDR_W-1:0]];

endmodule

### design/proximity_point_trigger_unit.sv
// Proximity point trigger unit: top level with request sequencer and scan pipeline.
// Depends on ppt_pkg and ppt_table.
//
// Usage:
//   req_* carries items. A write item (action 0) stores one track point and
//   clears its trigger latch. A check item (action 1) walks entries
//   0 .. points_in_use-1 (capped at the table depth) and emits one rsp_*
//   transfer for each entry that newly comes within the warning distance
//   ahead; the final one of a check carries last.
//   A check holds req_stall high after its acceptance until the walk ends,
//   also while the walk waits on the result side; the single read port of
//   the point memory sets the pace of one entry per cycle while not paused.
//   Each trigger is held until the next trigger or the end of the walk; the
//   final result is offered as the walk ends.
//   csr_* writes warning distance, re-arm distance and points in use; it is
//   always ready and should only be used while no check is in flight.
//   Results sit in an output register; under rsp_stall the walk pauses only
//   when a trigger is found with both the held trigger and the output full.
//   Reset (synchronous) clears all trigger latches and restores registers;
//   point memory contents are undefined until written.
module proximity_point_trigger_unit #(
   parameter int MAX_POINTS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ppt_pkg::ppt_req_type                  req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ppt_pkg::ppt_rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ppt_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [ppt_pkg::DIST_BITS-1:0]         csr_data
);
   import ppt_pkg::*;

   localparam int DEPTH = (MAX_POINTS < MAX_SCAN) ? MAX_POINTS : MAX_SCAN;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Configuration registers
   logic [DIST_BITS-1:0]   warn_ff;
   logic [DIST_BITS-1:0]   rearm_ff;
   logic [POINTS_BITS-1:0] points_ff;

   // Sequencer
   ppt_state_type state_ff, state_in;
   logic          scan_active;

   // Current check
   logic [POS_BITS-1:0] cur_pos_ff;
   logic [DIR_BITS-1:0] cur_dir_ff;
   logic                cur_any_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issue_idx_ff;

   // Pipeline stages
   logic                        s1_valid_ff;
   logic [IDX_BITS-1:0]         s1_idx_ff;
   logic                        s2_valid_ff;
   logic [IDX_BITS-1:0]         s2_idx_ff;
   logic signed [DIFF_BITS-1:0] s2_diff_ff;
   logic                        s2_match_ff;

   // Held trigger waiting to learn whether it is the last
   logic                 held_valid_ff;
   logic [IDX_BITS-1:0]  held_idx_ff;
   logic [DIST_BITS-1:0] held_dist_ff;

   // Output register
   logic        rsp_valid_ff;
   ppt_rsp_type rsp_data_ff;

   // Table interface
   ppt_tbl_ctl_type tbl_ctl;
   ppt_entry_type   rd_entry;
   logic            latch_q;

   // Datapath terms
   logic                        req_accept;
   logic                        check_accept;
   logic                        wr_ok;
   logic                        out_free;
   logic signed [DIFF_BITS-1:0] warn_ext;
   logic signed [DIFF_BITS-1:0] rearm_neg;
   logic signed [DIFF_BITS-1:0] diff_c;
   logic                        match_c;
   logic                        in_win;
   logic                        s2_trig;
   logic                        s2_rearm;
   logic                        advance;
   logic                        issue_done;
   logic                        pipe_empty;
   logic                        issuing;
   logic                        push_mid;
   logic                        push_last;
   logic                        scan_end;
   logic                        pop;

   ppt_table #(
      .DEPTH (DEPTH)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctl      (tbl_ctl),
      .rd_entry (rd_entry),
      .latch_q  (latch_q)
   );

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_ff   <= WARN_RESET;
         rearm_ff  <= REARM_RESET;
         points_ff <= POINTS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WARNING: warn_ff   <= csr_data;
            CSR_REARM:   rearm_ff  <= csr_data;
            CSR_POINTS:  points_ff <= csr_data[POINTS_BITS-1:0];
            default:     ;
         endcase
      end
   end

   // Handshake and hazard terms
   always_comb begin
      req_accept   = req_valid && !req_stall;
      check_accept = req_accept && (req_data.action == ACT_CHECK);
      wr_ok        = req_accept && (req_data.action == ACT_WRITE)
                     && (32'(req_data.entry_index) < DEPTH);
      pop          = rsp_valid_ff && !rsp_stall;
      out_free     = !rsp_valid_ff || !rsp_stall;

      warn_ext  = $signed({{(DIFF_BITS - DIST_BITS){1'b0}}, warn_ff});
      rearm_neg = -$signed({{(DIFF_BITS - DIST_BITS){1'b0}}, rearm_ff});
      diff_c    = $signed({1'b0, rd_entry.position}) - $signed({1'b0, cur_pos_ff});
      match_c   = cur_any_ff || (rd_entry.direction == cur_dir_ff);

      in_win   = (s2_diff_ff > 0) && (s2_diff_ff <= warn_ext);
      s2_trig  = s2_valid_ff && s2_match_ff && in_win && !latch_q;
      s2_rearm = s2_valid_ff && s2_match_ff && !in_win && (s2_diff_ff < rearm_neg);

      // Freeze the walk when a second trigger has nowhere to go
      advance    = !(s2_trig && held_valid_ff && !out_free);
      issue_done = (issue_idx_ff == count_ff);
      pipe_empty = !s1_valid_ff && !s2_valid_ff;
      issuing    = scan_active && !issue_done && advance;
      push_mid   = s2_trig && held_valid_ff && out_free;
      push_last  = scan_active && issue_done && pipe_empty && held_valid_ff && out_free;
      scan_end   = scan_active && issue_done && pipe_empty
                   && (!held_valid_ff || out_free);

      if (32'(points_ff) > DEPTH) begin
         count_in = CNT_W'(DEPTH);
      end else begin
         count_in = CNT_W'(points_ff);
      end
   end

   // Table access
   always_comb begin
      tbl_ctl                    = '0;
      tbl_ctl.wr_en              = wr_ok;
      tbl_ctl.wr_idx             = req_data.entry_index;
      tbl_ctl.wr_entry.position  = req_data.position_mm;
      tbl_ctl.wr_entry.direction = req_data.direction;
      tbl_ctl.rd_en              = issuing;
      tbl_ctl.rd_idx             = IDX_BITS'(issue_idx_ff);
      tbl_ctl.lat_en             = wr_ok || (advance && (s2_trig || s2_rearm));
      tbl_ctl.lat_idx            = scan_active ? s2_idx_ff : req_data.entry_index;
      tbl_ctl.lat_val            = scan_active && s2_trig;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (check_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            scan_active = 1'b0;
         end
         ST_SCAN: begin
            req_stall   = 1'b1;
            scan_active = 1'b1;
         end
         default: begin
            req_stall   = 1'b1;
            scan_active = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issue_idx_ff  <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Start or advance the walk
         if (check_accept) begin
            count_ff     <= count_in;
            issue_idx_ff <= '0;
         end else if (issuing) begin
            issue_idx_ff <= issue_idx_ff + 1'b1;
         end

         if (advance) begin
            s1_valid_ff <= issuing;
            s2_valid_ff <= s1_valid_ff;
         end

         // Hold the newest trigger; drop it once sent as last
         if (s2_trig && advance) begin
            held_valid_ff <= 1'b1;
         end else if (push_last) begin
            held_valid_ff <= 1'b0;
         end

         if (push_mid || push_last) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (check_accept) begin
         cur_pos_ff <= req_data.position_mm;
         cur_dir_ff <= req_data.direction;
         cur_any_ff <= req_data.direction_any;
      end
      if (advance) begin
         s1_idx_ff   <= IDX_BITS'(issue_idx_ff);
         s2_idx_ff   <= s1_idx_ff;
         s2_diff_ff  <= diff_c;
         s2_match_ff <= match_c;
      end
      if (s2_trig && advance) begin
         held_idx_ff  <= s2_idx_ff;
         held_dist_ff <= s2_diff_ff[DIST_BITS-1:0];
      end
      if (push_mid || push_last) begin
         rsp_data_ff.point_index <= held_idx_ff;
         rsp_data_ff.distance_mm <= held_dist_ff;
         rsp_data_ff.last        <= push_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### design/ppt_checker.sv
// Port-level checker for the proximity point trigger unit, bound to the top level.
// Depends on ppt_pkg and proximity_point_trigger_unit_assert.svh.
`include "proximity_point_trigger_unit_assert.svh"

module ppt_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input ppt_pkg::ppt_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ppt_pkg::ppt_rsp_type rsp_data
);
   import ppt_pkg::*;

   // A stalled result stays offered and unchanged
   `PPT_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped under stall")
   `PPT_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "result changed under stall")

   // A check transfer occupies the block in the next cycle
   `PPT_ASSERT_RST(a_check_busy, clock, reset, req_valid && !req_stall && req_data.action == ACT_CHECK |=> req_stall, "check accepted but block not busy")

   // A trigger always lies strictly ahead
   `PPT_ASSERT_RST(a_dist_nonzero, clock, reset, rsp_valid |-> rsp_data.distance_mm != '0, "zero trigger distance")

   // Reset leaves the block idle with nothing to deliver
   `PPT_ASSERT(a_reset_idle, clock, reset |=> !rsp_valid && !req_stall, "block not idle after reset")

endmodule

bind proximity_point_trigger_unit ppt_checker u_ppt_checker (.*);

### sim/tb_proximity_point_trigger_unit.sv
// Self-checking testbench for proximity_point_trigger_unit: random stimulus,
// random idling on both channels and a scoreboard that predicts every trigger.
// Depends on ppt_pkg and the proximity_point_trigger_unit RTL.
`timescale 1ns / 100ps

import ppt_pkg::*;

// Tracks the point table, the trigger latches and the registers, and holds
// the triggers that each accepted check is due to produce
class trigger_scoreboard;
   logic [POS_BITS-1:0]    point_pos [MAX_SCAN];
   logic [DIR_BITS-1:0]    point_dir [MAX_SCAN];
   bit                     latched   [MAX_SCAN];
   logic [DIST_BITS-1:0]   warn_mm;
   logic [DIST_BITS-1:0]   rearm_mm;
   logic [POINTS_BITS-1:0] points_used;
   ppt_rsp_type            expected_triggers [$];
   int                     mismatches;
   int                     triggers_seen;
   int                     writes_seen;
   int                     checks_seen;

   function new();
      warn_mm       = WARN_RESET;
      rearm_mm      = REARM_RESET;
      points_used   = POINTS_RESET;
      mismatches    = 0;
      triggers_seen = 0;
      writes_seen   = 0;
      checks_seen   = 0;
      for (int i = 0; i < MAX_SCAN; i++) begin
         point_pos[i] = '0;
         point_dir[i] = '0;
         latched[i]   = 1'b0;
      end
   endfunction

   function int pending();
      return expected_triggers.size();
   endfunction

   // Unknown indexes are dropped
   function void set_register(logic [CSR_IDX_BITS-1:0] idx, logic [DIST_BITS-1:0] value);
      case (idx)
         CSR_WARNING: warn_mm = value;
         CSR_REARM:   rearm_mm = value;
         CSR_POINTS:  points_used = value[POINTS_BITS-1:0];
         default: ;
      endcase
   endfunction

   function void note_item(ppt_req_type item);
      int          scan;
      longint      ahead;
      ppt_rsp_type hit;
      ppt_rsp_type found [$];
      // Store the point and release its latch
      if (item.action == ACT_WRITE) begin
         point_pos[item.entry_index] = item.position_mm;
         point_dir[item.entry_index] = item.direction;
         latched[item.entry_index]   = 1'b0;
         writes_seen++;
         return;
      end
      checks_seen++;
      scan = (points_used > MAX_SCAN) ? MAX_SCAN : int'(points_used);
      // Walk the entries in use, lowest index first
      for (int i = 0; i < scan; i++) begin
         if (!item.direction_any && point_dir[i] != item.direction)
            continue;
         ahead = longint'(point_pos[i]) - longint'(item.position_mm);
         if (ahead > 0 && ahead <= longint'(warn_mm)) begin
            if (!latched[i]) begin
               latched[i]      = 1'b1;
               hit.point_index = IDX_BITS'(i);
               hit.distance_mm = DIST_BITS'(ahead);
               hit.last        = 1'b0;
               found.push_back(hit);
            end
         end else if (ahead < -longint'(rearm_mm)) begin
            latched[i] = 1'b0;
         end
      end
      // Flag the final trigger of this check
      if (found.size() > 0)
         found[found.size()-1].last = 1'b1;
      foreach (found[k])
         expected_triggers.push_back(found[k]);
   endfunction

   function void check_trigger(ppt_rsp_type got);
      ppt_rsp_type want;
      triggers_seen++;
      if (expected_triggers.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] unexpected trigger: index %0d distance %0d last %0b",
                     $time, got.point_index, got.distance_mm, got.last);
         return;
      end
      want = expected_triggers.pop_front();
      if (got.point_index !== want.point_index || got.distance_mm !== want.distance_mm ||
          got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] trigger differs: expected index %0d distance %0d last %0b, %s",
                     $time, want.point_index, want.distance_mm, want.last,
                     $sformatf("got index %0d distance %0d last %0b",
                               got.point_index, got.distance_mm, got.last));
      end
   endfunction
endclass

module tb_proximity_point_trigger_unit;
   localparam int                      SETTLE_CYCLES  = MAX_SCAN + 16;
   localparam int                      WATCHDOG_LIMIT = 2000;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED     = 2'd3;
   localparam logic [POS_BITS-1:0]     POS_TOP        = '1;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   ppt_req_type              req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   ppt_rsp_type              rsp_data;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [DIST_BITS-1:0]     csr_data  = '0;

   bit                       idling_on        = 1'b1;
   int                       settings_applied = 0;

   // Stimulus-side copy of the table, used to aim checks at stored points
   logic [POS_BITS-1:0]      laid_pos [MAX_SCAN];
   logic [DIR_BITS-1:0]      laid_dir [MAX_SCAN];
   bit                       laid     [MAX_SCAN];
   logic [POS_BITS-1:0]      track_base;
   logic [DIST_BITS-1:0]     cur_warn;
   logic [DIST_BITS-1:0]     cur_rearm;
   int                       cur_points;

   trigger_scoreboard board = new();

   proximity_point_trigger_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   function automatic ppt_req_type make_item(ppt_action_type act, logic [IDX_BITS-1:0] slot,
                                             logic [POS_BITS-1:0] pos,
                                             logic [DIR_BITS-1:0] dir, logic any);
      ppt_req_type item;
      item.action        = act;
      item.entry_index   = slot;
      item.position_mm   = pos;
      item.direction     = dir;
      item.direction_any = any;
      return item;
   endfunction

   function automatic logic [POS_BITS-1:0] random_position();
      return POS_BITS'({$urandom(), $urandom()});
   endfunction

   // Offer one item and hold it until the transfer; valid stays high afterwards
   task automatic send_item(input ppt_req_type item);
      if (item.action == ACT_WRITE) begin
         laid[item.entry_index]     = 1'b1;
         laid_pos[item.entry_index] = item.position_mm;
         laid_dir[item.entry_index] = item.direction;
      end
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Drop valid, wait for every outstanding trigger, then let a silent walk finish
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all registers plus the unused index, keeping valid high between transfers
   task automatic apply_settings(logic [DIST_BITS-1:0] warn, logic [DIST_BITS-1:0] rearm,
                                 logic [DIST_BITS-1:0] points);
      logic [CSR_IDX_BITS-1:0] idx   [4];
      logic [DIST_BITS-1:0]    value [4];
      idx   = '{CSR_UNUSED, CSR_WARNING, CSR_REARM, CSR_POINTS};
      value = '{DIST_BITS'($urandom()), warn, rearm, points};
      for (int k = 0; k < 4; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= value[k];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid  <= 1'b0;
      cur_warn   = warn;
      cur_rearm  = rearm;
      cur_points = (points[POINTS_BITS-1:0] > MAX_SCAN) ? MAX_SCAN
                                                        : int'(points[POINTS_BITS-1:0]);
      settings_applied++;
   endtask

   task automatic run_phase(logic [DIST_BITS-1:0] warn, logic [DIST_BITS-1:0] rearm,
                            logic [DIST_BITS-1:0] points, int items, bit idle);
      int                  span;
      int                  slot;
      int                  pick;
      longint              ahead;
      logic [POS_BITS-1:0] spot;
      ppt_req_type         item;
      drain_and_settle();
      apply_settings(warn, rearm, points);
      idling_on  = idle;
      track_base = random_position();
      span       = 4 * int'(warn) + 2000;
      // Lay every slot in use that has never been written
      for (int i = 0; i < cur_points; i++) begin
         if (!laid[i]) begin
            spot = track_base + POS_BITS'($urandom_range(0, span));
            send_item(make_item(ACT_WRITE, IDX_BITS'(i), spot, DIR_BITS'($urandom()), 1'b0));
         end
      end
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // Move a point along the track, mostly among the slots in use
            slot = (cur_points > 0 && $urandom_range(0, 1) == 1)
                   ? $urandom_range(0, cur_points - 1) : $urandom_range(0, MAX_SCAN - 1);
            spot = track_base + POS_BITS'($urandom_range(0, span));
            item = make_item(ACT_WRITE, IDX_BITS'(slot), spot, DIR_BITS'($urandom()),
                             1'(($urandom())));
         end else if (pick < 40 || cur_points == 0) begin
            // Noise: anywhere on the full position range
            item = make_item(ppt_action_type'($urandom_range(0, 1)), IDX_BITS'($urandom()),
                             random_position(), DIR_BITS'($urandom()), 1'($urandom()));
         end else begin
            // Aim a check at one stored point, around the window and re-arm edges
            slot = $urandom_range(0, cur_points - 1);
            case ($urandom_range(0, 7))
               0:       ahead = 1;
               1:       ahead = longint'(cur_warn);
               2:       ahead = longint'(cur_warn) + 1;
               3:       ahead = 0;
               4:       ahead = -longint'(cur_rearm);
               5:       ahead = -longint'(cur_rearm) - 1;
               6:       ahead = $urandom_range(1, (cur_warn == 0) ? 1 : int'(cur_warn));
               default: ahead = -longint'($urandom_range(0, 3 * int'(cur_rearm) + 10));
            endcase
            spot = POS_BITS'(longint'(laid_pos[slot]) - ahead);
            item = make_item(ACT_CHECK, IDX_BITS'($urandom()), spot,
                             ($urandom_range(0, 3) != 0) ? laid_dir[slot] : DIR_BITS'($urandom()),
                             ($urandom_range(0, 4) == 0));
         end
         send_item(item);
      end
   endtask

   // Random stall bursts on the result side
   initial begin : result_stall
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Observe every transfer on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            board.set_register(csr_index, csr_data);
         if (req_valid && !req_stall)
            board.note_item(req_data);
         if (rsp_valid && !rsp_stall)
            board.check_trigger(rsp_data);
      end
   end

   // End the run if no transfer happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      for (int i = 0; i < MAX_SCAN; i++)
         laid[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: hand-placed points around the reset window
      apply_settings(WARN_RESET, REARM_RESET, 20'd8);
      send_item(make_item(ACT_WRITE, 6'd0, '0, 2'd0, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd1, POS_TOP, 2'd3, 1'b1));
      send_item(make_item(ACT_WRITE, 6'd2, 36'd100000, 2'd1, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd3, 36'd100000, 2'd2, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd4, 36'd130000, 2'd1, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd5, 36'd90000, 2'd1, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd6, 36'd500000, 2'd0, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd7, 36'd500001, 2'd3, 1'b0));
      send_item(make_item(ACT_WRITE, 6'd63, 36'h5_5555_5555, 2'd2, 1'b0));
      // Window edge and inside, then the same check again against the latches
      send_item(make_item(ACT_CHECK, 6'd63, 36'd70000, 2'd1, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, 36'd70000, 2'd1, 1'b0));
      // Wildcard direction
      send_item(make_item(ACT_CHECK, 6'd21, 36'd70000, 2'd0, 1'b1));
      // Just past one point, and one beyond the re-arm distance
      send_item(make_item(ACT_CHECK, 6'd42, 36'd100001, 2'd1, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, 36'd100000, 2'd1, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, 36'd80000, 2'd1, 1'b0));
      // Top and bottom of the position range
      send_item(make_item(ACT_CHECK, 6'd0, POS_TOP - 36'd1, 2'd3, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, POS_TOP, 2'd3, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, '0, 2'd0, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, 36'd470000, 2'd0, 1'b0));
      // Rewrite a latched point, which must let it trigger again
      send_item(make_item(ACT_WRITE, 6'd2, 36'd100000, 2'd1, 1'b0));
      send_item(make_item(ACT_CHECK, 6'd0, 36'd70000, 2'd1, 1'b0));

      // Random phases over the register extremes; the last one runs without idling
      run_phase(20'd1, 20'd0, 20'd64, 10, 1'b1);
      run_phase(20'd1000000, 20'd1000000, 20'd127, 10, 1'b1);
      run_phase(20'd0, 20'hFFFFF, 20'd16, 10, 1'b1);
      run_phase(20'hFFFFF, 20'd500, 20'd33, 10, 1'b1);
      run_phase(20'd30000, 20'd10000, 20'd0, 4, 1'b1);
      run_phase(DIST_BITS'($urandom_range(1, 1000000)), DIST_BITS'($urandom_range(0, 1000000)),
                {13'($urandom()), 7'($urandom_range(1, 64))}, 12, 1'b0);
      drain_and_settle();

      $display("Run covered %0d table writes and %0d position checks, %0d triggers seen,",
               board.writes_seen, board.checks_seen, board.triggers_seen);
      $display("across %0d register settings; %0d mismatches.",
               settings_applied, board.mismatches);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

### proximity_point_trigger_unit.f
+incdir+design
design/ppt_pkg.sv
design/ppt_table.sv
design/proximity_point_trigger_unit.sv
design/ppt_checker.sv
sim/tb_proximity_point_trigger_unit.sv
